// File: src/crc16_packet_deframer_defines.svh
// Assertion macros shared by the crc16 deframer RTL.
// Depends on nothing; every user has clk_i and rst_ni in scope.
`ifndef CRC16_PACKET_DEFRAMER_DEFINES_SVH
`define CRC16_PACKET_DEFRAMER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define CRC16D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define CRC16D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

// File: src/crc16d_pkg.sv
// Shared types, constants and the CRC-16 byte update for the deframer.
// No dependencies.
package crc16d_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 1024;

  localparam logic [7:0]  SYNC_BYTE = 8'hAA;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME = 16'd18;

  localparam int unsigned MAX_LEN_W     = 11;
  localparam logic [10:0] MAX_LEN_RESET = 11'd1024;

  // register indexes on the config port
  localparam logic [0:0] REG_MAX_LEN = 1'b0;

  // header offsets
  localparam logic [10:0] OFS_FIRST   = 11'd2;
  localparam logic [10:0] OFS_CODE    = 11'd2;
  localparam logic [10:0] OFS_SEQ     = 11'd3;
  localparam logic [10:0] OFS_IDX_LO  = 11'd12;
  localparam logic [10:0] OFS_IDX_HI  = 11'd13;
  localparam logic [10:0] OFS_LEN_LO  = 11'd14;
  localparam logic [10:0] OFS_LEN_HI  = 11'd15;
  localparam logic [8:0]  OFS_DEST_WD = 9'd1;   // offsets 4..7
  localparam logic [8:0]  OFS_SRC_WD  = 9'd2;   // offsets 8..11

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC,
    PH_COLLECT,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_GOOD,
    ST_BAD_LEN,
    ST_BAD_CRC,
    ST_SHORT
  } status_e;

  typedef struct packed {
    logic [15:0] total_len;
    logic [15:0] fragment_index;
    logic [31:0] source_device;
    logic [31:0] dest_device;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_code;
    status_e     frame_status;
    logic        frame_end;
    logic [9:0]  byte_offset;
    logic [7:0]  frame_byte;
  } result_t;

  // reflected CRC-16, one byte, eight fixed shift/xor steps
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/crc16d_cfg_regs.sv
// APB-style register block holding max_frame_len.
// Depends on crc16d_pkg.
module crc16d_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [crc16d_pkg::MAX_LEN_W-1:0] max_len_o
);
  import crc16d_pkg::*;

  logic [MAX_LEN_W-1:0] max_len_q, max_len_d;
  logic                 sel_max_len;

  assign sel_max_len = (paddr[2] == REG_MAX_LEN);
  assign pready      = 1'b1;

  always_comb begin
    max_len_d = max_len_q;
    if (psel && penable && pwrite && sel_max_len) begin
      max_len_d = pwdata[MAX_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign prdata    = sel_max_len ? {{(32-MAX_LEN_W){1'b0}}, max_len_q} : 32'h0;
  assign max_len_o = max_len_q;

endmodule

// File: src/crc16d_parser.sv
// Input register plus the frame parser: sync hunt, header capture, CRC, checks.
// Depends on crc16d_pkg and crc16_packet_deframer_defines.svh.
`include "crc16_packet_deframer_defines.svh"

module crc16d_parser #(
  parameter int unsigned BUFFER_BYTES = crc16d_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic [crc16d_pkg::MAX_LEN_W-1:0] max_len_i,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output crc16d_pkg::result_t res_o
);
  import crc16d_pkg::*;

  localparam logic [15:0] BufLen = 16'(BUFFER_BYTES);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;

  // frame state
  phase_e      phase_q, phase_d;
  logic [10:0] offset_q, offset_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  seq_q, seq_d;
  logic [31:0] dest_q, dest_d;
  logic [31:0] src_q, src_d;
  logic [15:0] index_q, index_d;

  logic [15:0] limit;
  logic [16:0] len_m2;
  logic        res_valid;
  logic        end_f;
  status_e     status;
  result_t     res;

  assign advance    = in_valid_q && res_ready_i;
  assign in_ready_o = !in_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  assign limit  = ({5'b0, max_len_i} < BufLen) ? {5'b0, max_len_i} : BufLen;
  assign len_m2 = {1'b0, length_q} - 17'd2;

  always_comb begin
    phase_d   = phase_q;
    offset_d  = offset_q;
    crc_d     = crc_q;
    length_d  = length_q;
    crc_lo_d  = crc_lo_q;
    code_d    = code_q;
    seq_d     = seq_q;
    dest_d    = dest_q;
    src_d     = src_q;
    index_d   = index_q;
    res_valid = 1'b0;
    end_f     = 1'b0;
    status    = ST_GOOD;
    res       = '0;

    unique case (phase_q)
      PH_HUNT: begin
        if (in_byte_q == SYNC_BYTE) begin
          crc_d   = crc_update(CRC_INIT, in_byte_q);
          phase_d = PH_SYNC;
        end
      end
      PH_SYNC: begin
        if (in_byte_q == SYNC_BYTE) begin
          crc_d    = crc_update(crc_q, in_byte_q);
          offset_d = OFS_FIRST;
          length_d = '0;
          crc_lo_d = '0;
          code_d   = '0;
          seq_d    = '0;
          dest_d   = '0;
          src_d    = '0;
          index_d  = '0;
          phase_d  = PH_COLLECT;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        res_valid = 1'b1;
        // header capture
        if (offset_q == OFS_CODE) begin
          code_d = in_byte_q;
        end
        if (offset_q == OFS_SEQ) begin
          seq_d = in_byte_q;
        end
        if (offset_q[10:2] == OFS_DEST_WD) begin
          dest_d[8*offset_q[1:0] +: 8] = in_byte_q;
        end
        if (offset_q[10:2] == OFS_SRC_WD) begin
          src_d[8*offset_q[1:0] +: 8] = in_byte_q;
        end
        if (offset_q == OFS_IDX_LO) begin
          index_d = {8'h00, in_byte_q};
        end
        if (offset_q == OFS_IDX_HI) begin
          index_d = {in_byte_q, index_q[7:0]};
        end
        if (offset_q == OFS_LEN_LO) begin
          length_d = {8'h00, in_byte_q};
        end
        if (offset_q == OFS_LEN_HI) begin
          length_d = {in_byte_q, length_q[7:0]};
        end

        priority if (offset_q <= OFS_LEN_HI) begin
          crc_d = crc_update(crc_q, in_byte_q);
          if (offset_q == OFS_LEN_HI && (length_d < MIN_FRAME || length_d > limit)) begin
            end_f  = 1'b1;
            status = ST_BAD_LEN;
          end
        end else if ({6'b0, offset_q} < len_m2) begin
          crc_d = crc_update(crc_q, in_byte_q);
        end else if ({6'b0, offset_q} == len_m2) begin
          crc_lo_d = in_byte_q;
        end else begin
          end_f  = 1'b1;
          status = ({in_byte_q, crc_lo_q} == crc_q) ? ST_GOOD : ST_BAD_CRC;
        end

        if (!end_f && in_last_q) begin
          end_f  = 1'b1;
          status = ST_SHORT;
        end

        res.frame_byte  = in_byte_q;
        res.byte_offset = offset_q[9:0];
        res.frame_end   = end_f;
        if (end_f) begin
          res.frame_status   = status;
          res.frame_code     = code_d;
          res.frame_seq      = seq_d;
          res.dest_device    = dest_d;
          res.source_device  = src_d;
          res.fragment_index = index_d;
          res.total_len      = length_d;
          phase_d = (status == ST_GOOD) ? PH_DONE : PH_HUNT;
        end else begin
          offset_d = offset_q + 11'd1;
        end
      end
      PH_DONE: begin
        // rest of the burst is dropped
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    if (in_last_q) begin
      phase_d = PH_HUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      offset_q <= '0;
      crc_q    <= CRC_INIT;
      length_q <= '0;
      crc_lo_q <= '0;
      code_q   <= '0;
      seq_q    <= '0;
      dest_q   <= '0;
      src_q    <= '0;
      index_q  <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      crc_q    <= crc_d;
      length_q <= length_d;
      crc_lo_q <= crc_lo_d;
      code_q   <= code_d;
      seq_q    <= seq_d;
      dest_q   <= dest_d;
      src_q    <= src_d;
      index_q  <= index_d;
    end
  end

  assign res_valid_o = advance && res_valid;
  assign res_o       = res;

  `CRC16D_ASSERT(a_collect_offset, (phase_q == PH_COLLECT) |-> (offset_q >= OFS_FIRST),
    "collecting below the first frame offset")
  `CRC16D_ASSERT(a_good_goes_done,
    (advance && res_valid && res.frame_end && res.frame_status == ST_GOOD && !in_last_q)
      |=> (phase_q == PH_DONE),
    "good frame did not park the parser")
  `CRC16D_ASSERT(a_burst_end_hunts, (advance && in_last_q) |=> (phase_q == PH_HUNT),
    "burst end did not return to hunting")

endmodule

// File: src/crc16d_out_stage.sv
// Result register with a skid entry; ready depends only on registered state.
// Depends on crc16d_pkg and crc16_packet_deframer_defines.svh.
`include "crc16_packet_deframer_defines.svh"

module crc16d_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  crc16d_pkg::result_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output crc16d_pkg::result_t pop_data_o
);
  import crc16d_pkg::*;

  logic    main_v_q, main_v_d;
  logic    skid_v_q, skid_v_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    push, pop;

  assign push_ready_o = !skid_v_q;
  assign push         = push_valid_i && !skid_v_q;
  assign pop          = main_v_q && pop_ready_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_d   = push_data_i;
        skid_v_d = push;
      end else begin
        main_d   = push_data_i;
        main_v_d = push;
      end
    end else if (push) begin
      skid_d   = push_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign pop_valid_o = main_v_q;
  assign pop_data_o  = main_q;

  `CRC16D_ASSERT_ALWAYS(a_skid_needs_main, skid_v_q |-> main_v_q,
    "skid entry held while result register empty")
  `CRC16D_ASSERT(a_held_push_to_skid, (push && main_v_q && !pop) |=> skid_v_q,
    "transaction behind a stalled result was lost")
  `CRC16D_ASSERT(a_drain_empties, (pop && !skid_v_q && !push) |=> !main_v_q,
    "result register still valid after its last transaction left")

endmodule

// File: src/crc16_packet_deframer.sv
// Top level of the CRC-16 packet deframer: APB register, parser, output stage.
// Depends on crc16d_pkg, crc16d_cfg_regs, crc16d_parser, crc16d_out_stage.
//
// Takes one received byte per transaction on the slave stream (tlast marks the
// end of a receive burst), hunts for two 0xAA sync bytes and then streams out
// every frame byte from offset 2 onward with its offset. The frame is code,
// sequence, 4-byte destination, 4-byte source, 16-bit index, 16-bit little
// endian total length, payload and a CRC-16 (reflected 0xA001, init 0xFFFF,
// low byte first) over all bytes before it, sync bytes included. The last
// result of a candidate has tlast set, its status in tuser (0 good, 1 bad
// length, 2 bad CRC, 3 cut short by the burst end) and the header fields in
// tdata; on other results those fields are zero. Lengths below 18 or above
// min(max_frame_len, BUFFER_BYTES) are rejected at offset 15. A rejected
// candidate resumes the hunt at the next byte; after a good frame the rest of
// the burst is dropped. Throughput is one byte per clock while the output
// stage can take results: the CRC byte update is fixed XOR logic between the
// input register and the parser state, so a byte can enter every such cycle.
// A byte is held in the input register and its result in the result register.
// The result register has a skid entry, so s_axis_tready depends only on
// registered state and the slave side keeps moving while one result waits on
// m_axis_tready. max_frame_len (address 0, 11 bits, reset 1024) is to be
// written by the user only while idle; the block itself does not enforce it.
module crc16_packet_deframer #(
  parameter int unsigned BUFFER_BYTES = crc16d_pkg::BUFFER_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // received byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  logic         s_axis_tlast,   // burst_end
  // frame byte stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] frame_byte, [17:8] byte_offset, [25:18] frame_code,
  // [33:26] frame_seq, [65:34] dest_device, [97:66] source_device,
  // [113:98] fragment_index, [129:114] total_len, [135:130] zero
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast,   // frame_end
  output logic [1:0]   m_axis_tuser,   // [1:0] frame_status
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import crc16d_pkg::*;

  logic [MAX_LEN_W-1:0] max_len;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  result_t              out;

  crc16d_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  crc16d_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .max_len_i   (max_len),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  crc16d_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_ready_o (res_ready),
    .push_data_i  (res),
    .pop_valid_o  (m_axis_tvalid),
    .pop_ready_i  (m_axis_tready),
    .pop_data_o   (out)
  );

  assign m_axis_tdata = {6'b0, out.total_len, out.fragment_index, out.source_device,
                         out.dest_device, out.frame_seq, out.frame_code,
                         out.byte_offset, out.frame_byte};
  assign m_axis_tlast = out.frame_end;
  assign m_axis_tuser = out.frame_status;

endmodule
